@@ rtl/core/dmcas_pkg.sv @@
// shared types and constants of the direct-mapped cache-aside store
// no dependencies
package dmcas_pkg;

  localparam int unsigned KEY_W  = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef struct packed {
    logic fill;
    logic inval;
    logic flush;
  } cache_cmd_t;

endpackage

@@ rtl/core/dmcas_slot_idx.sv @@
// slot index unit: key modulo the entry count by reciprocal multiply
// depends on dmcas_pkg
module dmcas_slot_idx #(
  parameter int unsigned CACHE_ENTRIES = 128
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [dmcas_pkg::KEY_W-1:0]           key_i,
  output logic [(CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1)-1:0] idx_o
);

  localparam int unsigned IDX_W = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned SH    = 23;
  localparam int unsigned RECIP = (32'd1 << SH) / CACHE_ENTRIES + 1;
  localparam logic [23:0] RECIP_L = 24'(RECIP);
  localparam logic [12:0] CENT_L  = 13'(CACHE_ENTRIES);

  logic [dmcas_pkg::KEY_W-1:0] key_q;
  logic [dmcas_pkg::KEY_W-1:0] quo_q, quo_d;
  logic [34:0]                 prod;
  logic [23:0]                 back;
  logic [23:0]                 diff;

  assign prod  = 35'(key_i) * 35'(RECIP_L);
  assign quo_d = prod[SH+dmcas_pkg::KEY_W-1:SH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_i;
      quo_q <= quo_d;
    end
  end

  assign back  = 24'(quo_q) * 24'(CENT_L);
  assign diff  = 24'(key_q) - back;
  assign idx_o = diff[IDX_W-1:0];

endmodule

@@ rtl/core/dmcas_store.sv @@
// backing store memory with the fill sweep after reset
// depends on dmcas_pkg
module dmcas_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr_i,
  input  logic [dmcas_pkg::DATA_W-1:0]      wr_data_i,
  output logic [dmcas_pkg::DATA_W-1:0]      rd_data_o,
  output logic                              init_done_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [dmcas_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dmcas_pkg::DATA_W-1:0] rd_data_q;
  logic [AW-1:0]                cnt_q, cnt_d;
  logic                         busy_q, busy_d;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[cnt_q] <= dmcas_pkg::DATA_W'(cnt_q) + dmcas_pkg::DATA_W'(1);
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o   = rd_data_q;
  assign init_done_o = !busy_q;

endmodule

@@ rtl/core/dmcas_cache.sv @@
// cache slot memory (key and data) with flip-flop valid bits
// depends on dmcas_pkg
module dmcas_cache #(
  parameter int unsigned CACHE_ENTRIES = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [(CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1)-1:0] rd_idx_i,
  input  logic [(CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1)-1:0] wr_idx_i,
  input  dmcas_pkg::cache_cmd_t                 cmd_i,
  input  logic [dmcas_pkg::KEY_W-1:0]           wr_key_i,
  input  logic [dmcas_pkg::DATA_W-1:0]          wr_data_i,
  output logic                                  rd_valid_o,
  output logic [dmcas_pkg::KEY_W-1:0]           rd_key_o,
  output logic [dmcas_pkg::DATA_W-1:0]          rd_data_o
);

  logic [dmcas_pkg::KEY_W-1:0]  mem_key  [CACHE_ENTRIES];
  logic [dmcas_pkg::DATA_W-1:0] mem_data [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0]     valid_q, valid_d;
  logic                         rd_valid_q;
  logic [dmcas_pkg::KEY_W-1:0]  rd_key_q;
  logic [dmcas_pkg::DATA_W-1:0] rd_data_q;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.flush) begin
      valid_d = '0;
    end else if (cmd_i.fill) begin
      valid_d[wr_idx_i] = 1'b1;
    end else if (cmd_i.inval) begin
      valid_d[wr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      mem_key[wr_idx_i]  <= wr_key_i;
      mem_data[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_key_q   <= mem_key[rd_idx_i];
      rd_data_q  <= mem_data[rd_idx_i];
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_key_o   = rd_key_q;
  assign rd_data_o  = rd_data_q;

endmodule

@@ rtl/core/direct_mapped_cache_aside_store_top.sv @@
// direct-mapped cache in front of a backing store, top level
// depends on dmcas_pkg, dmcas_slot_idx, dmcas_store, dmcas_cache
//
// input channel: in_valid_i/in_ready_o with op_i, key_i, value_i
// output channel: out_valid_o/out_ready_i with hit_o, error_o, read_data_o
// every item (read, write, flush or unused code) gives exactly one result item
// after reset the backing store is filled with index plus one, one entry per
// cycle, with in_ready_o low until the fill is done
// each item goes through these steps: slot index computed and store read
// issued at acceptance, slot memory read next cycle, compare and write back
// in S_EVAL; no new item is taken until S_EVAL ends, at which point the
// result is written to the output register
// the result sits in an output register; the next item is accepted while it
// waits, and evaluation of that next item holds until the register is free
// a write to the store and a fill of a slot land before the next item's
// memory reads are issued, so no forwarding path is needed
module direct_mapped_cache_aside_store_top #(
  parameter int unsigned STORE_DEPTH   = 1024,
  parameter int unsigned CACHE_ENTRIES = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dmcas_pkg::OP_W-1:0]            op_i,
  input  logic [dmcas_pkg::KEY_W-1:0]           key_i,
  input  logic signed [dmcas_pkg::DATA_W-1:0]   value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o,
  output logic                                  error_o,
  output logic signed [dmcas_pkg::DATA_W-1:0]   read_data_o
);

  localparam int unsigned MEM_DEPTH = STORE_DEPTH < 2048 ? STORE_DEPTH : 2048;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned IDX_W     = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [16:0] DEPTH_L   = 17'(STORE_DEPTH);

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_ADDR = 4'b0100,
    S_EVAL = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  dmcas_pkg::op_e               op_q;
  logic [dmcas_pkg::KEY_W-1:0]  key_q;
  logic [dmcas_pkg::DATA_W-1:0] value_q;
  logic [IDX_W-1:0]             idx_q, idx;
  logic                         out_valid_q, out_valid_d;
  logic                         hit_q, hit_d;
  logic                         error_q, error_d;
  logic [dmcas_pkg::DATA_W-1:0] rdata_q, rdata_d;

  logic                         accept;
  logic                         eval_go;
  logic                         init_done;
  logic [dmcas_pkg::DATA_W-1:0] st_rdata;
  logic                         st_wr_en;
  logic                         c_valid;
  logic [dmcas_pkg::KEY_W-1:0]  c_key;
  logic [dmcas_pkg::DATA_W-1:0] c_data;
  dmcas_pkg::cache_cmd_t        cmd;
  logic                         in_range;
  logic                         match;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign eval_go    = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);

  dmcas_slot_idx #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_idx (
    .clk_i (clk_i),
    .en_i  (accept),
    .key_i (key_i),
    .idx_o (idx)
  );

  dmcas_store #(
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (key_i[AW-1:0]),
    .wr_en_i     (st_wr_en),
    .wr_addr_i   (key_q[AW-1:0]),
    .wr_data_i   (value_q),
    .rd_data_o   (st_rdata),
    .init_done_o (init_done)
  );

  dmcas_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_cache (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (state_q == S_ADDR),
    .rd_idx_i   (idx),
    .wr_idx_i   (idx_q),
    .cmd_i      (cmd),
    .wr_key_i   (key_q),
    .wr_data_i  (st_rdata),
    .rd_valid_o (c_valid),
    .rd_key_o   (c_key),
    .rd_data_o  (c_data)
  );

  assign in_range = {6'd0, key_q} < DEPTH_L;
  assign match    = c_valid && (c_key == key_q);

  always_comb begin
    st_wr_en = 1'b0;
    cmd      = '0;
    hit_d    = 1'b0;
    error_d  = 1'b0;
    rdata_d  = '0;
    if (eval_go) begin
      unique case (op_q)
        dmcas_pkg::OP_READ: begin
          if (!in_range) begin
            error_d = 1'b1;
          end else if (match) begin
            hit_d   = 1'b1;
            rdata_d = c_data;
          end else begin
            rdata_d  = st_rdata;
            cmd.fill = 1'b1;
          end
        end
        dmcas_pkg::OP_WRITE: begin
          if (!in_range) begin
            error_d = 1'b1;
          end else begin
            st_wr_en  = 1'b1;
            cmd.inval = match;
          end
        end
        dmcas_pkg::OP_FLUSH: begin
          cmd.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: if (init_done) state_d = S_IDLE;
      S_IDLE: if (accept) state_d = S_ADDR;
      S_ADDR: state_d = S_EVAL;
      S_EVAL: if (eval_go) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (eval_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= dmcas_pkg::op_e'(op_i);
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (state_q == S_ADDR) begin
      idx_q <= idx;
    end
    if (eval_go) begin
      hit_q   <= hit_d;
      error_q <= error_d;
      rdata_q <= rdata_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign error_o     = error_q;
  assign read_data_o = rdata_q;

endmodule
